>>> hw/rtl/aabb_pkg.sv
// ----------------------------------------------------------------------------
// aabb_pkg
// Shared types and constants for the box store and overlap checker.
// ----------------------------------------------------------------------------
`default_nettype none

package aabb_pkg;

  // Store depth and the widths that follow from it
  localparam int unsigned MaxBoxes = 64;
  localparam int unsigned IdxW     = (MaxBoxes > 1) ? $clog2(MaxBoxes) : 1;
  localparam int unsigned CntW     = $clog2(MaxBoxes + 1);

  // Field widths
  localparam int unsigned PosW = 32;
  localparam int unsigned LenW = 31;

  // Item modes
  localparam logic MODE_ADD   = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic signed [PosW-1:0] pos_x;
    logic signed [PosW-1:0] pos_y;
    logic        [LenW-1:0] box_w;
    logic        [LenW-1:0] box_h;
  } box_t;

  localparam int unsigned BoxW = $bits(box_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_e;

endpackage

`default_nettype wire

>>> hw/rtl/aabb_ram.sv
// ----------------------------------------------------------------------------
// aabb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module aabb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                                         clk_i,
  input  wire logic                                         we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                             wdata_i,
  input  wire logic                                         re_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output      logic [Width-1:0]                             rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/aabb_cmp.sv
// ----------------------------------------------------------------------------
// aabb_cmp
// Strict overlap test of two boxes; edge sums formed at 33 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module aabb_cmp
  import aabb_pkg::*;
(
  input  wire box_t a_i,
  input  wire box_t b_i,
  output logic      hit_o
);

  localparam int unsigned SumW = PosW + 1;

  logic signed [SumW-1:0] ax_lo, ay_lo, bx_lo, by_lo;
  logic signed [SumW-1:0] ax_hi, ay_hi, bx_hi, by_hi;

  always_comb begin
    ax_lo = SumW'($signed(a_i.pos_x));
    ay_lo = SumW'($signed(a_i.pos_y));
    bx_lo = SumW'($signed(b_i.pos_x));
    by_lo = SumW'($signed(b_i.pos_y));
    ax_hi = ax_lo + $signed({2'b00, a_i.box_w});
    ay_hi = ay_lo + $signed({2'b00, a_i.box_h});
    bx_hi = bx_lo + $signed({2'b00, b_i.box_w});
    by_hi = by_lo + $signed({2'b00, b_i.box_h});
    // touching edges do not count
    hit_o = (ax_hi > bx_lo) && (bx_hi > ax_lo) &&
            (ay_hi > by_lo) && (by_hi > ay_lo);
  end

endmodule

`default_nettype wire

>>> hw/rtl/aabb_store_overlap_check_top.sv
// ----------------------------------------------------------------------------
// aabb_store_overlap_check_top
// Box store with an overlap query against every stored box.
// ----------------------------------------------------------------------------
// Timing: an add, or a query with nothing to scan (empty store, zero-size
//   box, checks off), strobes in the cycle after start; a scan, after ST_DRAIN.
// Throughput: adds every cycle while idle; a scanning query holds busy
//   through ST_SCAN and ST_DRAIN, one RAM read per cycle into one compare.
// Reset: box count cleared, check_enable set; store contents are not cleared.
// The receiver cannot stall: each result is valid for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module aabb_store_overlap_check_top
  import aabb_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // item channel
  input  wire logic                   start,
  output      logic                   busy,
  input  wire logic                   mode_i,
  input  wire logic signed [PosW-1:0] pos_x_i,
  input  wire logic signed [PosW-1:0] pos_y_i,
  input  wire logic        [LenW-1:0] box_width_i,
  input  wire logic        [LenW-1:0] box_height_i,
  // config channel
  input  wire logic                   cfg_valid_i,
  output      logic                   cfg_ready_o,
  input  wire logic                   cfg_data_i,
  // result channel
  output      logic                   out_valid_o,
  output      logic                   overlap_o,
  output      logic                   add_dropped_o,
  output      logic [CntW-1:0]        stored_count_o
);

  state_e          state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            hit_q, hit_d;
  logic            rd_vld_q;
  box_t            qry_q, qry_d;
  logic            cfg_en_q;
  logic            res_vld_q, res_vld_d;
  logic            overlap_q, overlap_d;
  logic            dropped_q, dropped_d;

  box_t            in_box;
  logic            accept;
  logic            full;
  logic            ram_we;
  logic            ram_re;
  box_t            ram_rdata;
  logic            cmp_hit;
  logic [CntW-1:0] last_cnt;
  logic            last_idx;

  assign in_box = '{pos_x: pos_x_i, pos_y: pos_y_i, box_w: box_width_i,
                    box_h: box_height_i};

  assign busy        = (state_q != ST_IDLE);
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;
  assign full        = (count_q >= CntW'(MaxBoxes));
  assign last_cnt    = count_q - CntW'(1);
  assign last_idx    = (idx_q == last_cnt[IdxW-1:0]);

  // Store write happens at an accepted add while not full; scan reads one entry per cycle
  assign ram_we = accept && (mode_i == MODE_ADD) && !full;
  assign ram_re = (state_q == ST_SCAN);

  aabb_ram #(
    .Width (BoxW),
    .Depth (MaxBoxes)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[IdxW-1:0]),
    .wdata_i (in_box),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  aabb_cmp u_cmp (
    .a_i   (qry_q),
    .b_i   (ram_rdata),
    .hit_o (cmp_hit)
  );

  // Sequencer
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    idx_d     = idx_q;
    hit_d     = hit_q;
    qry_d     = qry_q;
    res_vld_d = 1'b0;
    overlap_d = 1'b0;
    dropped_d = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (mode_i == MODE_ADD) begin
            res_vld_d = 1'b1;
            if (full) begin
              dropped_d = 1'b1;
            end else begin
              count_d = count_q + CntW'(1);
            end
          end else if (!cfg_en_q || (count_q == '0) ||
                       ((box_width_i == '0) && (box_height_i == '0))) begin
            // nothing to scan: report no overlap right away
            res_vld_d = 1'b1;
          end else begin
            qry_d   = in_box;
            idx_d   = '0;
            hit_d   = 1'b0;
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (rd_vld_q && cmp_hit) begin
          hit_d = 1'b1;
        end
        idx_d = idx_q + IdxW'(1);
        if (last_idx) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last entry's read data lands here
        res_vld_d = 1'b1;
        overlap_d = hit_q || (rd_vld_q && cmp_hit);
        state_d   = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      rd_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
      cfg_en_q  <= 1'b1;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      rd_vld_q  <= ram_re;
      res_vld_q <= res_vld_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_en_q <= cfg_data_i;
      end
    end
  end

  // Payload, no reset needed
  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    hit_q     <= hit_d;
    qry_q     <= qry_d;
    overlap_q <= overlap_d;
    dropped_q <= dropped_d;
  end

  assign out_valid_o    = res_vld_q;
  assign overlap_o      = overlap_q;
  assign add_dropped_o  = dropped_q;
  assign stored_count_o = count_q;

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxBoxes))
    else $error("box count exceeds store depth");

  a_add_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (mode_i == MODE_ADD) && !full) |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("accepted add did not bump count");

  a_drain_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |=> (out_valid_o && !add_dropped_o))
    else $error("scan end without query result");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(overlap_o && add_dropped_o))
    else $error("overlap and drop flagged together");

endmodule

`default_nettype wire

>>> tb/aabb_store_overlap_check_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// aabb_store_overlap_check_checker
// Watches the item, config and result channels of the box store. It keeps its
// own copy of the stored boxes, the count and check_enable, works out the
// result of every accepted item, and compares the results field by field, in
// order.
// ----------------------------------------------------------------------------

module aabb_store_overlap_check_checker
  import aabb_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic                   busy_i,
  input  logic                   mode_i,
  input  logic signed [PosW-1:0] pos_x_i,
  input  logic signed [PosW-1:0] pos_y_i,
  input  logic        [LenW-1:0] box_width_i,
  input  logic        [LenW-1:0] box_height_i,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic                   cfg_data_i,
  input  logic                   out_valid_i,
  input  logic                   overlap_i,
  input  logic                   add_dropped_i,
  input  logic [CntW-1:0]        stored_count_i,
  output int                     fail_count_o,
  output int                     pending_o
);

  typedef struct packed {
    logic            overlap;
    logic            add_dropped;
    logic [CntW-1:0] stored_count;
  } box_result_t;

  box_t            shadow_boxes [MaxBoxes];
  logic [CntW-1:0] shadow_count;
  logic            shadow_enable;
  box_result_t     due_results [$];

  // Edge sums are taken at 64 bits, so nothing wraps
  function automatic bit spans_cross(input longint a_lo, input longint a_len,
                                     input longint b_lo, input longint b_len);
    return (a_lo + a_len > b_lo) && (b_lo + b_len > a_lo);
  endfunction

  function automatic box_result_t apply_box_item(input logic item_mode, input box_t b);
    box_result_t r;
    box_t        s;
    int          i;
    r = '0;
    if (item_mode == MODE_ADD) begin
      if (int'(shadow_count) < MaxBoxes) begin
        shadow_boxes[int'(shadow_count)] = b;
        shadow_count = shadow_count + 1'b1;
      end else begin
        r.add_dropped = 1'b1;
      end
    end else if ((b.box_w != '0 || b.box_h != '0) && shadow_enable) begin
      for (i = 0; i < int'(shadow_count); i++) begin
        s = shadow_boxes[i];
        if (spans_cross(longint'($signed(b.pos_x)), longint'(b.box_w),
                        longint'($signed(s.pos_x)), longint'(s.box_w)) &&
            spans_cross(longint'($signed(b.pos_y)), longint'(b.box_h),
                        longint'($signed(s.pos_y)), longint'(s.box_h)))
          r.overlap = 1'b1;
      end
    end
    r.stored_count = shadow_count;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    box_t        item;
    box_result_t want;
    if (!rst_ni) begin
      shadow_count  = '0;
      shadow_enable = 1'b1;
      due_results.delete();
    end else begin
      if (out_valid_i) begin
        if (due_results.size() == 0) begin
          $error("result with no item outstanding: overlap %0b dropped %0b count %0d",
                 overlap_i, add_dropped_i, stored_count_i);
          fail_count_o++;
        end else begin
          want = due_results.pop_front();
          if (overlap_i !== want.overlap) begin
            $error("overlap: expected %0b, got %0b", want.overlap, overlap_i);
            fail_count_o++;
          end
          if (add_dropped_i !== want.add_dropped) begin
            $error("add_dropped: expected %0b, got %0b", want.add_dropped, add_dropped_i);
            fail_count_o++;
          end
          if (stored_count_i !== want.stored_count) begin
            $error("stored_count: expected %0d, got %0d", want.stored_count,
                   stored_count_i);
            fail_count_o++;
          end
        end
      end
      // an item taken at this edge still sees the old check_enable
      if (start_i && !busy_i) begin
        item.pos_x = pos_x_i;
        item.pos_y = pos_y_i;
        item.box_w = box_width_i;
        item.box_h = box_height_i;
        due_results.push_back(apply_box_item(mode_i, item));
      end
      if (cfg_valid_i && cfg_ready_i)
        shadow_enable = cfg_data_i;
    end
    pending_o = due_results.size();
  end

endmodule

>>> tb/aabb_store_overlap_check_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// aabb_store_overlap_check_top_tb
// Drives boxes into the store and queries them back. A short directed run hits
// touching edges, the 32-bit extremes, zero-size queries and disabled checks;
// then random phases, each with its own check_enable, mix clustered boxes,
// near-touching queries and raw values, and fill the store past full. The
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------

module aabb_store_overlap_check_top_tb;
  import aabb_pkg::*;

  localparam int CycleLimit = 500_000;
  // Sized to cover the longest scan, one that reads a full store
  localparam int DrainCycles = MaxBoxes + 8;
  localparam int NumPhases = 8;
  localparam int PhaseItems = 80;
  // Total adds reached by forcing adds in the fill phase, so the store overflows for sure
  localparam int FillAdds = MaxBoxes + 8;

  localparam logic signed [PosW-1:0] PosMin = {1'b1, {(PosW-1){1'b0}}};
  localparam logic signed [PosW-1:0] PosMax = {1'b0, {(PosW-1){1'b1}}};
  localparam logic        [LenW-1:0] LenMax = {LenW{1'b1}};

  logic                   clk_i          = 1'b0;
  logic                   rst_ni         = 1'b0;
  logic                   start          = 1'b0;
  logic                   busy;
  logic                   mode_i         = MODE_ADD;
  logic signed [PosW-1:0] pos_x_i        = '0;
  logic signed [PosW-1:0] pos_y_i        = '0;
  logic        [LenW-1:0] box_width_i    = '0;
  logic        [LenW-1:0] box_height_i   = '0;
  logic                   cfg_valid_i    = 1'b0;
  logic                   cfg_ready_o;
  logic                   cfg_data_i     = 1'b1;
  logic                   out_valid_o;
  logic                   overlap_o;
  logic                   add_dropped_o;
  logic [CntW-1:0]        stored_count_o;

  int fail_cnt;
  int pending_cnt;
  int cycle_cnt = 0;

  // Stimulus bookkeeping only: boxes sent as adds, used to aim queries at
  // their edges
  box_t placed_boxes [$];
  int   adds_sent = 0;
  // Chance in percent of an idle burst after each item; 0 keeps start high
  int   gap_pct   = 25;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  aabb_store_overlap_check_top i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .mode_i         (mode_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .box_width_i    (box_width_i),
    .box_height_i   (box_height_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .out_valid_o    (out_valid_o),
    .overlap_o      (overlap_o),
    .add_dropped_o  (add_dropped_o),
    .stored_count_o (stored_count_o)
  );

  aabb_store_overlap_check_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .mode_i         (mode_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .box_width_i    (box_width_i),
    .box_height_i   (box_height_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .out_valid_i    (out_valid_o),
    .overlap_i      (overlap_o),
    .add_dropped_i  (add_dropped_o),
    .stored_count_i (stored_count_o),
    .fail_count_o   (fail_cnt),
    .pending_o      (pending_cnt)
  );

  // Hang guard
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Called at a rising edge. Holds start high until the block takes the item;
  // busy is looked at mid-cycle, where it is settled. Returns at the edge that
  // accepted the item with start still high, or after an idle burst with start low.
  task automatic send_box(input logic m, input logic signed [PosW-1:0] x,
                          input logic signed [PosW-1:0] y,
                          input logic [LenW-1:0] w, input logic [LenW-1:0] h);
    box_t b;
    start        <= 1'b1;
    mode_i       <= m;
    pos_x_i      <= x;
    pos_y_i      <= y;
    box_width_i  <= w;
    box_height_i <= h;
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    if (m == MODE_ADD) begin
      b.pos_x = x;
      b.pos_y = y;
      b.box_w = w;
      b.box_h = h;
      placed_boxes.push_back(b);
      adds_sent++;
    end
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  endtask

  // Drop start and wait until every result is back and the block is idle.
  // Every item yields a result, so an empty queue means nothing in flight.
  task automatic wait_quiet();
    start <= 1'b0;
    @(negedge clk_i);
    while (pending_cnt != 0 || busy) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_enable(input logic en);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= en;
    @(negedge clk_i);
    while (!cfg_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [PosW-1:0] pick_pos();
    case ($urandom_range(0, 3))
      0:       return PosMin;
      1:       return PosMax;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  function automatic logic [LenW-1:0] pick_len();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return LenW'(1);
      2:       return LenMax;
      default: return LenW'($urandom());
    endcase
  endfunction

  // Half are small boxes around the origin so that queries really hit; the
  // rest are zero-size, aim at the edges of stored boxes (off by one LSB either
  // way), sit at the coordinate extremes, or are raw 32-bit values.
  function automatic box_t pick_box();
    box_t b;
    box_t near;
    int   kind;
    kind = $urandom_range(0, 15);
    if (kind >= 9 && kind <= 10 && placed_boxes.size() == 0)
      kind = 0;
    b.pos_x = PosW'($urandom_range(0, 511)) - PosW'(256);
    b.pos_y = PosW'($urandom_range(0, 511)) - PosW'(256);
    b.box_w = LenW'($urandom_range(0, 128));
    b.box_h = LenW'($urandom_range(0, 128));
    if (kind == 8) begin
      // zero-size box
      b.box_w = '0;
      b.box_h = '0;
    end else if (kind >= 9 && kind <= 10) begin
      near    = placed_boxes[$urandom_range(0, placed_boxes.size() - 1)];
      b.pos_x = near.pos_x;
      b.pos_y = near.pos_y;
      case ($urandom_range(0, 3))
        0: b.pos_x = near.pos_x + PosW'(near.box_w) + PosW'($urandom_range(0, 2)) - PosW'(1);
        1: b.pos_x = near.pos_x - PosW'(b.box_w) + PosW'($urandom_range(0, 2)) - PosW'(1);
        2: b.pos_y = near.pos_y + PosW'(near.box_h) + PosW'($urandom_range(0, 2)) - PosW'(1);
        default: b.pos_y = near.pos_y - PosW'(b.box_h) + PosW'($urandom_range(0, 2)) - PosW'(1);
      endcase
    end else if (kind >= 11 && kind <= 12) begin
      b.pos_x = pick_pos();
      b.pos_y = pick_pos();
      b.box_w = pick_len();
      b.box_h = pick_len();
    end else if (kind >= 13) begin
      b.pos_x = PosW'($urandom());
      b.pos_y = PosW'($urandom());
      b.box_w = LenW'($urandom());
      b.box_h = LenW'($urandom());
    end
    return b;
  endfunction

  initial begin : stimulus
    box_t b;
    logic m;
    int   p;
    int   n;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed part ----
    // query against an empty store
    send_box(MODE_QUERY, 32'sd0, 32'sd0, 31'd256, 31'd256);
    // unit box at the origin (Q24.8: 256 is 1.0)
    send_box(MODE_ADD, 32'sd0, 32'sd0, 31'd256, 31'd256);
    // zero width and height: never overlaps, even inside a box
    send_box(MODE_QUERY, 32'sd64, 32'sd64, 31'd0, 31'd0);
    send_box(MODE_QUERY, 32'sd64, 32'sd64, 31'd1, 31'd1);
    // touching right, top and left edges do not count
    send_box(MODE_QUERY, 32'sd256, 32'sd0, 31'd256, 31'd256);
    send_box(MODE_QUERY, 32'sd0, 32'sd256, 31'd256, 31'd256);
    send_box(MODE_QUERY, -32'sd256, 32'sd0, 31'd256, 31'd256);
    // one LSB past the corner does
    send_box(MODE_QUERY, -32'sd256, -32'sd256, 31'd257, 31'd257);
    // zero width with nonzero height is still a real query
    send_box(MODE_QUERY, 32'sd64, 32'sd64, 31'd0, 31'd16);
    // boxes at both ends of the coordinate range; the upper one reaches past
    // 32 bits, which must not wrap
    send_box(MODE_ADD, PosMin, PosMin, LenMax, LenMax);
    send_box(MODE_ADD, PosMax, PosMax, LenMax, LenMax);
    send_box(MODE_QUERY, PosMax, PosMax, 31'd1, 31'd1);
    send_box(MODE_QUERY, PosMin, PosMin, 31'd1, 31'd1);
    // sits between the lower box (ends at -1) and the origin box
    send_box(MODE_QUERY, -32'sd1, -32'sd1, 31'd1, 31'd1);
    send_box(MODE_QUERY, PosMin, PosMax, LenMax, LenMax);
    // alternating bit patterns
    send_box(MODE_ADD, 32'h5555_5555, 32'hAAAA_AAAA, 31'h2AAA_AAAA, 31'h5555_5555);
    send_box(MODE_QUERY, 32'hAAAA_AAAA, 32'h5555_5555, 31'h5555_5555, 31'h2AAA_AAAA);
    // checks disabled: a sure hit reports nothing
    wait_quiet();
    write_enable(1'b0);
    send_box(MODE_QUERY, 32'sd64, 32'sd64, 31'd1, 31'd1);
    send_box(MODE_QUERY, 32'sd64, 32'sd64, 31'd0, 31'd0);
    wait_quiet();
    write_enable(1'b1);
    send_box(MODE_QUERY, 32'sd64, 32'sd64, 31'd1, 31'd1);

    // ---- random phases ----
    // Phases 2 and 5 run with checks off; phases 3 and 7 run without idle
    // bursts; phase 6 forces adds until FillAdds adds have been sent in all, so
    // the store is full and drops adds (the full-store case). The count never
    // shrinks, so the phases after it scan all entries.
    for (p = 0; p < NumPhases; p++) begin
      wait_quiet();
      write_enable((p == 2 || p == 5) ? 1'b0 : 1'b1);
      gap_pct = (p == 3 || p == NumPhases - 1) ? 0 : 25;
      for (n = 0; n < PhaseItems; n++) begin
        if (p == 6 && adds_sent < FillAdds)
          m = MODE_ADD;
        else
          m = ($urandom_range(0, 5) == 0) ? MODE_ADD : MODE_QUERY;
        b = pick_box();
        send_box(m, b.pos_x, b.pos_y, b.box_w, b.box_h);
      end
    end

    // ---- drain ----
    wait_quiet();
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_cnt == 0 && pending_cnt == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
